### src/fca_pkg.sv
// types, codes and helpers shared by the flow cache modules
package fca_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INACTIVE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LIMIT      = 2'd2;

    localparam logic [31:0] ACTIVE_TIMEOUT_RST   = 32'd60000;
    localparam logic [31:0] INACTIVE_TIMEOUT_RST = 32'd10000;
    localparam logic [5:0]  CACHE_LIMIT_RST      = 6'd32;

    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] FIN_RST_MASK = 8'h05;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [7:0]  tos;
        logic [31:0] packets;
        logic [31:0] bytes;
        logic [31:0] first_ms;
        logic [31:0] last_ms;
        logic [7:0]  flags;
    } flow_rec_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [7:0]  tos;
        logic [15:0] ip_length;
        logic [7:0]  flags;
    } pkt_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RD     = 7'b0000010,
        ST_EV     = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_EVICT  = 7'b0010000,
        ST_INSERT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        PH_INACT,
        PH_ACT,
        PH_SEARCH,
        PH_FLUSH
    } phase_t;

    // time since then, zero when the clock appears to run backwards
    function automatic logic [31:0] elapsed(input logic [31:0] now, input logic [31:0] then_ms);
        logic [31:0] d;
        begin
            d = now - then_ms;
            return (now >= then_ms) ? d : 32'd0;
        end
    endfunction

endpackage

### src/fca_entry_ram.sv
// flow entry memory, one write port and one registered read port
module fca_entry_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  fca_pkg::flow_rec_t   wr_data,
    input  logic [AW-1:0]        rd_addr,
    output fca_pkg::flow_rec_t   rd_data
);
    import fca_pkg::*;

    flow_rec_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### src/flow_cache_aggregator.sv
// flow cache top level: entry table sequencer, configuration and export stage
//
// One packet header (mode 0) or flush request (mode 1) enters on the in_valid /
// in_stall channel; in_stall stays high while an item is being processed.
// Exported flow records leave on out_valid / out_stall, one beat per record,
// with rec_final marking the last record caused by an input.
// A packet makes three passes over the entry memory: inactive timeout,
// active timeout, then key search with oldest and free slot tracking.
// Each pass visits every slot in turn: an empty slot is passed in ST_RD, an
// occupied one also waits in ST_EV for the registered memory read, and
// longer while an export has no room; a flush takes one pass. The entry
// memory has a single read port, which is why slots are read one at a time.
// Records go through a one-deep holding register into the output register,
// so the last one can be tagged; a stalled receiver holds the sequencer
// only when both are full.
// Reset empties the table (valid bits clear at once, no memory sweep) and
// restores the timeout and cache limit registers to their defaults.
// Configuration writes take effect at once and are meant for idle periods.
module flow_cache_aggregator #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] now_ms,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [7:0]  protocol,
    input  logic [7:0]  tos,
    input  logic [15:0] ip_length,
    input  logic [7:0]  pkt_flags,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] rec_src_addr,
    output logic [31:0] rec_dst_addr,
    output logic [15:0] rec_src_port,
    output logic [15:0] rec_dst_port,
    output logic [7:0]  rec_protocol,
    output logic [7:0]  rec_tos,
    output logic [31:0] rec_packets,
    output logic [31:0] rec_bytes,
    output logic [31:0] rec_first_ms,
    output logic [31:0] rec_last_ms,
    output logic [7:0]  rec_flags,
    output logic        rec_final
);
    import fca_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [6:0] CAP7 = 7'(CAPACITY);

    // configuration
    logic [31:0] act_to_reg;
    logic [31:0] inact_to_reg;
    logic [5:0]  limit_cfg_reg;
    logic [6:0]  limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_to_reg    <= ACTIVE_TIMEOUT_RST;
            inact_to_reg  <= INACTIVE_TIMEOUT_RST;
            limit_cfg_reg <= CACHE_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_ACTIVE_TIMEOUT)
            begin
                act_to_reg <= cfg_wr_data;
            end
            if (cfg_index == CFG_INACTIVE_TIMEOUT)
            begin
                inact_to_reg <= cfg_wr_data;
            end
            if (cfg_index == CFG_CACHE_LIMIT)
            begin
                limit_cfg_reg <= cfg_wr_data[5:0];
            end
        end
    end

    always_comb
    begin
        if (limit_cfg_reg == 6'd0)
        begin
            limit = 7'd1;
        end
        else if ({1'b0, limit_cfg_reg} > CAP7)
        begin
            limit = CAP7;
        end
        else
        begin
            limit = {1'b0, limit_cfg_reg};
        end
    end

    // sequencer state
    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    pkt_t             pkt_reg, pkt_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    flow_rec_t        hit_rec_reg, hit_rec_next;
    logic             old_found_reg, old_found_next;
    logic [IDX_W-1:0] old_idx_reg, old_idx_next;
    flow_rec_t        old_rec_reg, old_rec_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [IDX_W-1:0] ins_idx_reg, ins_idx_next;

    // export stage
    logic      pend_valid_reg, pend_valid_next;
    flow_rec_t pend_reg, pend_next;
    logic      out_valid_reg, out_valid_next;
    flow_rec_t out_reg, out_next;
    logic      out_final_reg, out_final_next;

    flow_rec_t ram_q;
    flow_rec_t new_rec;
    flow_rec_t emit_rec;
    logic      ram_we;
    logic      emit_en;
    logic      final_push;
    logic      out_free;
    logic      can_emit;
    logic      fin;
    logic      cond;
    logic      adv;
    logic      key_match;
    logic [32:0] byte_sum;

    fca_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ins_idx_reg),
        .wr_data (new_rec),
        .rd_addr (idx_reg),
        .rd_data (ram_q)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign can_emit = !pend_valid_reg || out_free;
    assign fin = (pkt_reg.protocol == PROTO_TCP) && ((pkt_reg.flags & FIN_RST_MASK) != 8'd0);
    assign key_match = (ram_q.src_addr == pkt_reg.src_addr) && (ram_q.dst_addr == pkt_reg.dst_addr)
                    && (ram_q.src_port == pkt_reg.src_port) && (ram_q.dst_port == pkt_reg.dst_port)
                    && (ram_q.protocol == pkt_reg.protocol) && (ram_q.tos == pkt_reg.tos);
    assign byte_sum = {1'b0, hit_rec_reg.bytes} + {17'd0, pkt_reg.ip_length};

    // entry contents after this packet
    always_comb
    begin
        if (hit_found_reg)
        begin
            new_rec = hit_rec_reg;
            if (hit_rec_reg.packets != COUNT_MAX)
            begin
                new_rec.packets = hit_rec_reg.packets + 32'd1;
            end
            new_rec.bytes   = byte_sum[32] ? COUNT_MAX : byte_sum[31:0];
            new_rec.last_ms = pkt_reg.now_ms;
        end
        else
        begin
            new_rec.src_addr  = pkt_reg.src_addr;
            new_rec.dst_addr  = pkt_reg.dst_addr;
            new_rec.src_port  = pkt_reg.src_port;
            new_rec.dst_port  = pkt_reg.dst_port;
            new_rec.protocol  = pkt_reg.protocol;
            new_rec.tos       = pkt_reg.tos;
            new_rec.packets   = 32'd1;
            new_rec.bytes     = {16'd0, pkt_reg.ip_length};
            new_rec.first_ms  = pkt_reg.now_ms;
            new_rec.last_ms   = pkt_reg.now_ms;
            new_rec.flags     = pkt_reg.flags;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        pkt_next        = pkt_reg;
        valid_next      = valid_reg;
        used_next       = used_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rec_next    = hit_rec_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_rec_next    = old_rec_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ins_idx_next    = ins_idx_reg;
        emit_en         = 1'b0;
        emit_rec        = ram_q;
        ram_we          = 1'b0;
        final_push      = 1'b0;
        cond            = 1'b0;
        adv             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pkt_next.now_ms    = now_ms;
                    pkt_next.src_addr  = src_addr;
                    pkt_next.dst_addr  = dst_addr;
                    pkt_next.src_port  = src_port;
                    pkt_next.dst_port  = dst_port;
                    pkt_next.protocol  = protocol;
                    pkt_next.tos       = tos;
                    pkt_next.ip_length = ip_length;
                    pkt_next.flags     = pkt_flags;
                    idx_next   = '0;
                    phase_next = mode ? PH_FLUSH : PH_INACT;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (valid_reg[idx_reg])
                begin
                    state_next = ST_EV;
                end
                else
                begin
                    if (phase_reg == PH_SEARCH && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    adv = 1'b1;
                end
            end
            ST_EV:
            begin
                unique case (phase_reg)
                    PH_INACT:  cond = elapsed(pkt_reg.now_ms, ram_q.last_ms) > inact_to_reg;
                    PH_ACT:    cond = elapsed(pkt_reg.now_ms, ram_q.first_ms) > act_to_reg;
                    PH_FLUSH:  cond = 1'b1;
                    PH_SEARCH:
                    begin
                        cond      = 1'b0;
                        used_next = used_reg + CNT_W'(1);
                        if (!hit_found_reg && key_match)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = idx_reg;
                            hit_rec_next   = ram_q;
                        end
                        // strict compare keeps the lowest slot on ties
                        if (!old_found_reg || ram_q.first_ms < old_rec_reg.first_ms)
                        begin
                            old_found_next = 1'b1;
                            old_idx_next   = idx_reg;
                            old_rec_next   = ram_q;
                        end
                    end
                    default: cond = 1'b0;
                endcase
                if (!cond || can_emit)
                begin
                    if (cond)
                    begin
                        emit_en             = 1'b1;
                        emit_rec            = ram_q;
                        valid_next[idx_reg] = 1'b0;
                    end
                    adv = 1'b1;
                end
            end
            ST_DECIDE:
            begin
                if (hit_found_reg)
                begin
                    ins_idx_next = hit_idx_reg;
                    state_next   = ST_INSERT;
                end
                else if (7'(used_reg) >= limit)
                begin
                    state_next = ST_EVICT;
                end
                else
                begin
                    ins_idx_next = free_idx_reg;
                    state_next   = ST_INSERT;
                end
            end
            ST_EVICT:
            begin
                if (can_emit)
                begin
                    emit_en                 = 1'b1;
                    emit_rec                = old_rec_reg;
                    valid_next[old_idx_reg] = 1'b0;
                    ins_idx_next = (free_found_reg && free_idx_reg < old_idx_reg)
                                 ? free_idx_reg : old_idx_reg;
                    state_next   = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (!fin || can_emit)
                begin
                    ram_we = 1'b1;
                    valid_next[ins_idx_reg] = !fin;
                    if (fin)
                    begin
                        emit_en  = 1'b1;
                        emit_rec = new_rec;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    final_push = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next slot or close the pass
        if (adv)
        begin
            if (idx_reg == LAST_IDX)
            begin
                idx_next = '0;
                unique case (phase_reg)
                    PH_INACT:
                    begin
                        phase_next = PH_ACT;
                        state_next = ST_RD;
                    end
                    PH_ACT:
                    begin
                        phase_next      = PH_SEARCH;
                        state_next      = ST_RD;
                        used_next       = '0;
                        hit_found_next  = 1'b0;
                        old_found_next  = 1'b0;
                        free_found_next = 1'b0;
                    end
                    PH_SEARCH: state_next = ST_DECIDE;
                    PH_FLUSH:  state_next = ST_DONE;
                    default:   state_next = ST_IDLE;
                endcase
            end
            else
            begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = ST_RD;
            end
        end

        // export stage: holding register feeds the output register
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        out_final_next  = out_final_reg;
        if (emit_en)
        begin
            pend_next       = emit_rec;
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_final_next = 1'b0;
                out_valid_next = 1'b1;
            end
        end
        if (final_push)
        begin
            out_next        = pend_reg;
            out_final_next  = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_INACT;
            idx_reg         <= '0;
            valid_reg       <= '0;
            used_reg        <= '0;
            hit_found_reg   <= 1'b0;
            old_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            valid_reg       <= valid_next;
            used_reg        <= used_next;
            hit_found_reg   <= hit_found_next;
            old_found_reg   <= old_found_next;
            free_found_reg  <= free_found_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg       <= pkt_next;
        hit_idx_reg   <= hit_idx_next;
        hit_rec_reg   <= hit_rec_next;
        old_idx_reg   <= old_idx_next;
        old_rec_reg   <= old_rec_next;
        free_idx_reg  <= free_idx_next;
        ins_idx_reg   <= ins_idx_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_final_reg <= out_final_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign rec_src_addr  = out_reg.src_addr;
    assign rec_dst_addr  = out_reg.dst_addr;
    assign rec_src_port  = out_reg.src_port;
    assign rec_dst_port  = out_reg.dst_port;
    assign rec_protocol  = out_reg.protocol;
    assign rec_tos       = out_reg.tos;
    assign rec_packets   = out_reg.packets;
    assign rec_bytes     = out_reg.bytes;
    assign rec_first_ms  = out_reg.first_ms;
    assign rec_last_ms   = out_reg.last_ms;
    assign rec_flags     = out_reg.flags;
    assign rec_final     = out_final_reg;

`ifndef SYNTHESIS
    a_no_pending_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("record left in holding register at end of item");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |-> can_emit)
        else $error("record exported with export stage full");

    a_scan_emit_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_en && state_reg == ST_EV) |=> !valid_reg[$past(idx_reg)])
        else $error("exported slot still valid");

    a_free_slot_exists: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && !hit_found_reg && 7'(used_reg) < limit) |-> free_found_reg)
        else $error("no free slot below cache limit");
`endif

endmodule

### sim/tb.sv
// testbench for the flow cache: directed table, then random phases against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fca_pkg::*;

    localparam int SLOTS = 32;
    localparam int SETTLE = 400;

    typedef struct {
        logic      mode;
        pkt_t      pkt;
        int        n_exp;
    } stim_row_t;

    typedef struct {
        flow_rec_t rec;
        logic      fin;
    } exp_rec_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ACTIVE_TIMEOUT;
    logic [31:0] cfg_wr_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic mode = 0;
    pkt_t pkt = '0;
    logic out_valid;
    logic out_stall = 0;
    flow_rec_t rec;
    logic rec_final;

    // predictor state
    logic [31:0] act_to, inact_to;
    logic [5:0]  lim_reg;
    logic        flow_live[SLOTS];
    flow_rec_t   flow_tab[SLOTS];
    exp_rec_t    exp_flows[$];

    int  errors = 0;
    int  n_items = 0;
    int  n_recs = 0;
    bit  calm = 0;
    pkt_t key_pool[12];

    flow_cache_aggregator #(.CAPACITY(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .now_ms(pkt.now_ms), .src_addr(pkt.src_addr), .dst_addr(pkt.dst_addr),
        .src_port(pkt.src_port), .dst_port(pkt.dst_port), .protocol(pkt.protocol),
        .tos(pkt.tos), .ip_length(pkt.ip_length), .pkt_flags(pkt.flags),
        .out_valid(out_valid), .out_stall(out_stall),
        .rec_src_addr(rec.src_addr), .rec_dst_addr(rec.dst_addr),
        .rec_src_port(rec.src_port), .rec_dst_port(rec.dst_port),
        .rec_protocol(rec.protocol), .rec_tos(rec.tos), .rec_packets(rec.packets),
        .rec_bytes(rec.bytes), .rec_first_ms(rec.first_ms), .rec_last_ms(rec.last_ms),
        .rec_flags(rec.flags), .rec_final(rec_final)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #20ms;
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 10);

    function automatic logic [31:0] since(logic [31:0] now, logic [31:0] then_ms);
        return (now >= then_ms) ? now - then_ms : 32'd0;
    endfunction

    function automatic void export_flow(int s);
        exp_rec_t e;
        e.rec = flow_tab[s];
        e.fin = 1'b0;
        exp_flows.push_back(e);
        flow_live[s] = 1'b0;
    endfunction

    // expected records of one accepted beat; returns how many
    function automatic int predict_exports(logic m, pkt_t p);
        int before_n, used, hit, old, lim;
        logic [32:0] sum;
        before_n = exp_flows.size();
        used = 0;
        hit = -1;
        old = -1;
        lim = (lim_reg == 0) ? 1 : (lim_reg > SLOTS) ? SLOTS : lim_reg;
        if (m)
        begin
            for (int s = 0; s < SLOTS; s++)
                if (flow_live[s]) export_flow(s);
        end
        else
        begin
            for (int s = 0; s < SLOTS; s++)
                if (flow_live[s] && since(p.now_ms, flow_tab[s].last_ms) > inact_to)
                    export_flow(s);
            for (int s = 0; s < SLOTS; s++)
                if (flow_live[s] && since(p.now_ms, flow_tab[s].first_ms) > act_to)
                    export_flow(s);
            for (int s = 0; s < SLOTS; s++)
                if (flow_live[s])
                begin
                    used++;
                    if (hit < 0 && flow_tab[s].src_addr == p.src_addr
                        && flow_tab[s].dst_addr == p.dst_addr
                        && flow_tab[s].src_port == p.src_port
                        && flow_tab[s].dst_port == p.dst_port
                        && flow_tab[s].protocol == p.protocol
                        && flow_tab[s].tos == p.tos)
                        hit = s;
                end
            if (hit >= 0)
            begin
                if (flow_tab[hit].packets != COUNT_MAX)
                    flow_tab[hit].packets++;
                sum = {1'b0, flow_tab[hit].bytes} + {17'd0, p.ip_length};
                flow_tab[hit].bytes = sum[32] ? COUNT_MAX : sum[31:0];
                flow_tab[hit].last_ms = p.now_ms;
            end
            else
            begin
                if (used >= lim)
                begin
                    for (int s = 0; s < SLOTS; s++)
                        if (flow_live[s] && (old < 0
                            || flow_tab[s].first_ms < flow_tab[old].first_ms))
                            old = s;
                    if (old >= 0) export_flow(old);
                end
                for (int s = 0; s < SLOTS; s++)
                    if (!flow_live[s] && hit < 0) hit = s;
                if (hit >= 0)
                begin
                    flow_live[hit] = 1'b1;
                    flow_tab[hit] = '{src_addr: p.src_addr, dst_addr: p.dst_addr,
                        src_port: p.src_port, dst_port: p.dst_port,
                        protocol: p.protocol, tos: p.tos, packets: 32'd1,
                        bytes: {16'd0, p.ip_length}, first_ms: p.now_ms,
                        last_ms: p.now_ms, flags: p.flags};
                end
            end
            if (hit >= 0 && p.protocol == PROTO_TCP && (p.flags & FIN_RST_MASK) != 0)
                export_flow(hit);
        end
        if (exp_flows.size() > before_n)
            exp_flows[exp_flows.size()-1].fin = 1'b1;
        return exp_flows.size() - before_n;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            exp_rec_t e;
            if (exp_flows.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, actual src %h dst %h",
                    $time, rec.src_addr, rec.dst_addr);
                errors++;
            end
            else
            begin
                e = exp_flows.pop_front();
                n_recs++;
                check_field("src_addr", e.rec.src_addr, rec.src_addr);
                check_field("dst_addr", e.rec.dst_addr, rec.dst_addr);
                check_field("src_port", 32'(e.rec.src_port), 32'(rec.src_port));
                check_field("dst_port", 32'(e.rec.dst_port), 32'(rec.dst_port));
                check_field("protocol", 32'(e.rec.protocol), 32'(rec.protocol));
                check_field("tos", 32'(e.rec.tos), 32'(rec.tos));
                check_field("packets", e.rec.packets, rec.packets);
                check_field("bytes", e.rec.bytes, rec.bytes);
                check_field("first_ms", e.rec.first_ms, rec.first_ms);
                check_field("last_ms", e.rec.last_ms, rec.last_ms);
                check_field("flags", 32'(e.rec.flags), 32'(rec.flags));
                check_field("final", 32'(e.fin), 32'(rec_final));
            end
        end

    // one beat on the input channel; called at a rising edge
    task automatic send_beat(logic m, pkt_t p, int n_typed);
        int n;
        if (!calm && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        pkt <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n = predict_exports(m, p);
        n_items++;
        if (n_typed >= 0 && n != n_typed)
        begin
            $display("%0t: record count mismatch, expected %0d, actual %0d",
                $time, n_typed, n);
            errors++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (exp_flows.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ACTIVE_TIMEOUT:   act_to = val;
            CFG_INACTIVE_TIMEOUT: inact_to = val;
            default:              lim_reg = val[5:0];
        endcase
    endtask

    task automatic set_config(logic [31:0] a, logic [31:0] i, logic [5:0] l);
        write_reg(CFG_ACTIVE_TIMEOUT, a);
        write_reg(CFG_INACTIVE_TIMEOUT, i);
        write_reg(CFG_CACHE_LIMIT, {26'd0, l});
        @(posedge clk);
    endtask

    function automatic pkt_t mk(logic [31:0] t, logic [31:0] sa, logic [31:0] da,
        logic [15:0] sp, logic [15:0] dp, logic [7:0] pr, logic [7:0] ts,
        logic [15:0] len, logic [7:0] fl);
        return '{now_ms: t, src_addr: sa, dst_addr: da, src_port: sp, dst_port: dp,
            protocol: pr, tos: ts, ip_length: len, flags: fl};
    endfunction

    task automatic random_phase(int count, int max_step);
        logic [31:0] t;
        pkt_t p;
        t = $urandom;
        foreach (key_pool[k])
        begin
            key_pool[k] = mk(0, $urandom, $urandom, 16'($urandom), 16'($urandom),
                ($urandom_range(2) != 0) ? PROTO_TCP : 8'($urandom), 8'($urandom), 0, 0);
        end
        for (int k = 0; k < count; k++)
        begin
            // mostly forward time, sometimes running backwards
            if ($urandom_range(99) < 5)
                t = t - $urandom_range(max_step);
            else
                t = t + $urandom_range(max_step);
            p = key_pool[$urandom_range(11)];
            if ($urandom_range(99) < 15)
                p = mk(0, $urandom, $urandom, 16'($urandom), 16'($urandom),
                    8'($urandom), 8'($urandom), 0, 0);
            p.now_ms = t;
            p.ip_length = 16'($urandom);
            p.flags = ($urandom_range(99) < 12) ? 8'($urandom) : 8'd0;
            send_beat($urandom_range(99) < 3, p, -1);
        end
    endtask

    stim_row_t rows[$];

    initial
    begin
        act_to = ACTIVE_TIMEOUT_RST;
        inact_to = INACTIVE_TIMEOUT_RST;
        lim_reg = CACHE_LIMIT_RST;
        foreach (flow_live[s]) flow_live[s] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{1'b0, mk(0, 32'h0a000001, 32'h0a000002, 1000, 80, PROTO_TCP, 0, 60, 8'h02), 0},
            '{1'b0, mk(5, 32'h0a000001, 32'h0a000002, 1000, 80, PROTO_TCP, 0, 16'hffff, 0), 0},
            '{1'b0, mk(10, 32'h0b000001, 32'h0b000002, 2000, 443, PROTO_TCP, 4, 40, 8'h01), 1},
            '{1'b0, mk(11, 32'h0c000001, 32'h0c000002, 3000, 22, PROTO_TCP, 0, 40, 8'h04), 1},
            '{1'b0, mk(12, 32'h0d000001, 32'h0d000002, 53, 53, 8'd17, 0, 90, 8'h05), 0},
            '{1'b0, mk(20, '1, '1, '1, '1, 8'hff, 8'hff, '1, 8'hff), 0},
            '{1'b0, mk(20, 0, 0, 0, 0, 0, 0, 0, 0), 0},
            '{1'b0, mk(3, 32'h0a000001, 32'h0a000002, 1000, 80, PROTO_TCP, 0, 1, 0), 0},
            '{1'b0, mk(10030, 32'h0e000001, 32'h0e000002, 1, 2, 8'd1, 0, 84, 0), -1},
            '{1'b1, mk($urandom, $urandom, $urandom, 0, 0, 0, 0, 0, 0), -1},
            '{1'b1, '0, 0},
            '{1'b0, mk('1, 32'h01020304, 32'h05060708, 9, 9, PROTO_TCP, 0, 1500, 0), 0},
            '{1'b0, mk(0, 32'h01020305, 32'h05060708, 9, 9, PROTO_TCP, 0, 1500, 0), 0},
            '{1'b1, '0, 2}
        };
        foreach (rows[r])
            send_beat(rows[r].mode, rows[r].pkt, rows[r].n_exp);
        drain();

        set_config(500, 200, 4);
        random_phase(50, 150);
        drain();
        set_config(0, '1, 1);
        random_phase(50, 4);
        drain();
        set_config('1, 0, 0);
        random_phase(50, 3);
        drain();
        set_config(60000, 10000, 32);
        random_phase(50, 3000);
        drain();
        calm = 1;
        set_config(2000, 700, 63);
        random_phase(50, 60);
        drain();
        calm = 0;
        // table still holds flows, so this limit sits below occupancy
        set_config(1500, 600, 3);
        random_phase(50, 50);
        send_beat(1'b1, '0, -1);
        drain();

        $display("%0d input beats sent over six configurations, %0d flow records checked",
            n_items, n_recs);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
